### src/median_filter_3x3_stream_defines.svh
// ----------------------------------------------------------------------------
// median_filter_3x3_stream_defines.svh
// Assertion macros shared by the 3x3 median filter RTL.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_STREAM_DEFINES_SVH
`define MEDIAN_FILTER_3X3_STREAM_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define MF3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MF3_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Register indexes and stream field widths of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

	// configuration register indexes
	localparam logic REG_IMAGE_COLS = 1'b0;
	localparam logic REG_IMAGE_ROWS = 1'b1;

	localparam int CFG_DATA_W  = 16;
	localparam int COLS_REG_W  = 11;
	localparam int ROWS_REG_W  = 16;

	// stream field widths
	localparam int PIX_FIELD_W = 16;
	localparam int ROW_FIELD_W = 16;
	localparam int COL_FIELD_W = 10;
	localparam int OUT_TDATA_W = 48;

	// reset geometry
	localparam logic [COLS_REG_W-1:0] COLS_RESET = 11'd3;
	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 16'd3;

endpackage

### src/median_filter_3x3_stream.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_stream
// 3x3 median filter over a raster pixel stream, results tagged with position.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata[15:0] pixel_in
// m_axis    out  m_axis_tvalid/tready      tdata pixel/row/col, tuser size_error,
//                                          tlast frame_last
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One pixel request per clock unless s_axis_tready stalls it. A result
// passes through s1, s2 and s3 into the output register. A pixel that
// yields two results (median plus border copy: last column from row 2 on,
// and the last row) holds s3 for a second emit. The line stores live in
// one single-port-write RAM of MAX_COLS words holding {row r-2, row r-1};
// it is read when a pixel is taken and written back one stage later. No
// clearing pass: words read before they are written within a frame never
// reach a median. Reset clears position, pipeline valids and geometry (3x3).
// Stalls propagate back stage by stage; bubbles are squeezed out.
//
module median_filter_3x3_stream #(
	parameter int PIXEL_BITS = 16,
	parameter int MAX_COLS   = 1024
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [mf3_pkg::PIX_FIELD_W-1:0]      s_axis_tdata,   // [15:0] pixel_in

	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [mf3_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // [15:0] pixel_out,
	                                                             // [31:16] out_row,
	                                                             // [41:32] out_col, rest 0
	output logic                                 m_axis_tuser,   // size_error
	output logic                                 m_axis_tlast,   // frame_last

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]       cfg_data
);

	`include "median_filter_3x3_stream_defines.svh"

	// effective pixel width: the field itself is 16 bits
	localparam int PW = (PIXEL_BITS < mf3_pkg::PIX_FIELD_W) ? PIXEL_BITS
	                                                        : mf3_pkg::PIX_FIELD_W;
	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = mf3_pkg::ROW_FIELD_W;

	typedef struct packed {
		logic          med;   // median of (row-1, col-1) pending
		logic          bord;  // border copy or error result pending
		logic          err;
		logic          last;
		logic [RW-1:0] row;
		logic [CW-1:0] col;
		logic [PW-1:0] pix;
	} tag_t;

	function automatic logic [PW-1:0] min2(input logic [PW-1:0] a, input logic [PW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [PW-1:0] max2(input logic [PW-1:0] a, input logic [PW-1:0] b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic [PW-1:0] med3(input logic [PW-1:0] a, input logic [PW-1:0] b,
	                                       input logic [PW-1:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// ------------------------------------------------------------------
	// geometry
	// ------------------------------------------------------------------
	logic [mf3_pkg::COLS_REG_W-1:0] cols_q;
	logic [mf3_pkg::ROWS_REG_W-1:0] rows_q;
	logic [CW-1:0]                  col_max;
	logic [RW-1:0]                  row_max;
	logic                           size_err;

	always_comb begin
		if (cols_q == '0) begin
			col_max = '0;
		end else if ({21'd0, cols_q} > 32'(MAX_COLS)) begin
			col_max = CW'(MAX_COLS - 1);
		end else begin
			col_max = CW'(cols_q - 11'd1);
		end
		row_max  = (rows_q == '0) ? '0 : rows_q - 16'd1;
		size_err = (cols_q < 11'd3) || (rows_q < 16'd3);
	end

	// ------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------
	logic          row_last, col_last, in_fire;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;

	logic          valid_s1, valid_s2, valid_s3, out_valid_q;
	tag_t          tag_s1, tag_s2, tag_s3, tag_in;
	logic          s1_fire, s2_ready, s2_fire, s3_ready, s3_emit, s3_done, out_free;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign s3_emit   = valid_s3 && (tag_s3.med || tag_s3.bord) && out_free;
	assign s3_done   = valid_s3 && (!(tag_s3.med || tag_s3.bord)
	                   || (out_free && !(tag_s3.med && tag_s3.bord)));
	assign s3_ready  = !valid_s3 || s3_done;
	assign s2_fire   = valid_s2 && s3_ready;
	assign s2_ready  = !valid_s2 || s3_ready;
	assign s1_fire   = valid_s1 && s2_ready;
	assign s_axis_tready = !valid_s1 || s2_ready;
	assign in_fire   = s_axis_tvalid && s_axis_tready;

	assign row_last = (row_q == row_max);
	assign col_last = (col_q == col_max);

	always_comb begin
		tag_in.err  = size_err;
		tag_in.med  = !size_err && (row_q >= 16'd2) && (col_q >= CW'(2));
		tag_in.bord = size_err || (row_q == '0) || row_last || (col_q == '0) || col_last;
		tag_in.last = row_last && col_last;
		tag_in.row  = row_q;
		tag_in.col  = col_q;
		tag_in.pix  = size_err ? '0 : s_axis_tdata[PW-1:0];
	end

	// ------------------------------------------------------------------
	// line store RAM: {row r-2, row r-1}, read on accept, written from s1
	// ------------------------------------------------------------------
	logic [2*PW-1:0] line_mem [MAX_COLS];
	logic [2*PW-1:0] rd_s1;
	logic [PW-1:0]   top_s1, mid_s1;
	logic            mem_we;

	assign top_s1 = rd_s1[2*PW-1:PW];
	assign mid_s1 = rd_s1[PW-1:0];
	assign mem_we = s1_fire && !tag_s1.err;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_s1 <= line_mem[col_q];
		end
		if (mem_we) begin
			line_mem[tag_s1.col] <= {mid_s1, tag_s1.pix};
		end
	end

	// ------------------------------------------------------------------
	// s1: sort current column; window keeps sorted columns c-2, c-1
	// ------------------------------------------------------------------
	logic [PW-1:0] cur_lo, cur_md, cur_hi;
	logic [PW-1:0] win_lo_q [2];
	logic [PW-1:0] win_md_q [2];
	logic [PW-1:0] win_hi_q [2];

	always_comb begin
		cur_lo = min2(min2(top_s1, mid_s1), tag_s1.pix);
		cur_hi = max2(max2(top_s1, mid_s1), tag_s1.pix);
		cur_md = med3(top_s1, mid_s1, tag_s1.pix);
	end

	// ------------------------------------------------------------------
	// s2: max of lows, median of mids, min of highs
	// ------------------------------------------------------------------
	logic [PW-1:0] lo_s2 [3];
	logic [PW-1:0] md_s2 [3];
	logic [PW-1:0] hi_s2 [3];
	logic [PW-1:0] lmax, mmed, hmin;

	always_comb begin
		lmax = max2(max2(lo_s2[0], lo_s2[1]), lo_s2[2]);
		mmed = med3(md_s2[0], md_s2[1], md_s2[2]);
		hmin = min2(min2(hi_s2[0], hi_s2[1]), hi_s2[2]);
	end

	// ------------------------------------------------------------------
	// s3: final median, result select
	// ------------------------------------------------------------------
	logic [PW-1:0] lmax_s3, mmed_s3, hmin_s3, med_val;

	assign med_val = med3(lmax_s3, mmed_s3, hmin_s3);

	// payload registers
	logic [PW-1:0]                   out_pix_q;
	logic [RW-1:0]                   out_row_q;
	logic [mf3_pkg::COL_FIELD_W-1:0] out_col_q;
	logic                            out_err_q, out_last_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tag_s1 <= tag_in;
		end
		if (mem_we) begin
			win_lo_q[0] <= win_lo_q[1];
			win_md_q[0] <= win_md_q[1];
			win_hi_q[0] <= win_hi_q[1];
			win_lo_q[1] <= cur_lo;
			win_md_q[1] <= cur_md;
			win_hi_q[1] <= cur_hi;
		end
		if (s1_fire) begin
			tag_s2   <= tag_s1;
			lo_s2[0] <= win_lo_q[0];
			lo_s2[1] <= win_lo_q[1];
			lo_s2[2] <= cur_lo;
			md_s2[0] <= win_md_q[0];
			md_s2[1] <= win_md_q[1];
			md_s2[2] <= cur_md;
			hi_s2[0] <= win_hi_q[0];
			hi_s2[1] <= win_hi_q[1];
			hi_s2[2] <= cur_hi;
		end
		if (s2_fire) begin
			tag_s3  <= tag_s2;
			lmax_s3 <= lmax;
			mmed_s3 <= mmed;
			hmin_s3 <= hmin;
		end else if (s3_emit && tag_s3.med && tag_s3.bord) begin
			tag_s3.med <= 1'b0;   // median went first, border copy follows
		end
		if (s3_emit) begin
			if (tag_s3.med) begin
				out_pix_q  <= med_val;
				out_row_q  <= tag_s3.row - 16'd1;
				out_col_q  <= mf3_pkg::COL_FIELD_W'(tag_s3.col - CW'(1));
				out_err_q  <= 1'b0;
				out_last_q <= 1'b0;
			end else begin
				out_pix_q  <= tag_s3.pix;
				out_row_q  <= tag_s3.row;
				out_col_q  <= mf3_pkg::COL_FIELD_W'(tag_s3.col);
				out_err_q  <= tag_s3.err;
				out_last_q <= tag_s3.last;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= mf3_pkg::COLS_RESET;
			rows_q      <= mf3_pkg::ROWS_RESET;
			row_q       <= '0;
			col_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mf3_pkg::REG_IMAGE_COLS: cols_q <= cfg_data[mf3_pkg::COLS_REG_W-1:0];
					mf3_pkg::REG_IMAGE_ROWS: rows_q <= cfg_data[mf3_pkg::ROWS_REG_W-1:0];
					default: ;
				endcase
				row_q <= '0;
				col_q <= '0;
			end else if (in_fire) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end

			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				valid_s2 <= 1'b1;
			end else if (s2_fire) begin
				valid_s2 <= 1'b0;
			end
			if (s2_fire) begin
				valid_s3 <= 1'b1;
			end else if (s3_done) begin
				valid_s3 <= 1'b0;
			end
			if (s3_emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_err_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_col_q, out_row_q, mf3_pkg::PIX_FIELD_W'(out_pix_q)};

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// write-back never collides with a read of the same column
	`MF3_ASSERT(a_no_ram_collision, (mem_we && in_fire) |-> (tag_s1.col != col_q), "line store read and write hit the same column")
	// a stalled s1 keeps its RAM read data
	`MF3_ASSERT(a_s1_hold, (valid_s1 && !s2_ready) |=> (valid_s1 && $stable(rd_s1)), "s1 lost data while stalled")
	// median results never come from an undersized image
	`MF3_ASSERT(a_no_err_median, (valid_s3 && tag_s3.med) |-> !tag_s3.err, "median pending on size error item")
	// output, s1 and s3 empty under reset
	`MF3_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!m_axis_tvalid && !valid_s1 && !valid_s3), "pipeline not empty in reset")

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 median filter stream. A directed table
// walks reset geometry, pixel extremes, size errors and zero dimensions.
// Random phases follow: small frames, partial frames and error geometries,
// then the start of the first row of a frame wider than the column
// limit, sent under a long receiver hold-off. Each accepted pixel runs
// through a local window/line-store predictor. Results are checked in
// order against the queue of pending results.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   PIX_FIELD_W    = mf3_pkg::PIX_FIELD_W;
	localparam int   ROW_FIELD_W    = mf3_pkg::ROW_FIELD_W;
	localparam int   COL_FIELD_W    = mf3_pkg::COL_FIELD_W;
	localparam int   OUT_TDATA_W    = mf3_pkg::OUT_TDATA_W;
	localparam int   CFG_DATA_W     = mf3_pkg::CFG_DATA_W;
	localparam int   COLS_REG_W     = mf3_pkg::COLS_REG_W;
	localparam int   ROWS_REG_W     = mf3_pkg::ROWS_REG_W;
	localparam logic REG_IMAGE_COLS = mf3_pkg::REG_IMAGE_COLS;
	localparam logic REG_IMAGE_ROWS = mf3_pkg::REG_IMAGE_ROWS;

	localparam int PIXEL_BITS  = 16;
	localparam int MAX_COLS    = 1024;
	localparam int TAIL_CYC    = 12;   // pipeline depth plus the two-result stall
	localparam int RND_PIXELS  = 530;
	localparam int WIDE_PIXELS = 96;   // start of the first row of the over-wide frame, all borders
	localparam int HOLD_CYC    = 300;

	// one output request, fields as the predictor sees them
	typedef struct packed {
		logic [PIX_FIELD_W-1:0] pix;
		logic [ROW_FIELD_W-1:0] row;
		logic [COL_FIELD_W-1:0] col;
		logic                   err;
		logic                   last;
	} result_t;

	typedef enum logic [1:0] {ROW_PIX, ROW_CFG} row_kind_t;

	// one line of the directed stimulus; want is used only when typed is set
	typedef struct packed {
		row_kind_t              kind;
		logic                   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic                   typed;
		result_t                want;
	} stim_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;
	typedef enum logic [1:0] {PX_FULL, PX_NARROW, PX_EXTREME, PX_RAMP} pix_style_t;

	logic clk;
	logic arst_n;

	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [PIX_FIELD_W-1:0] s_axis_tdata;    // [15:0] pixel_in

	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;    // [15:0] pixel_out, [31:16] out_row,
	                                         // [41:32] out_col, [47:42] zero
	logic                   m_axis_tuser;    // size_error
	logic                   m_axis_tlast;    // frame_last

	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	median_filter_3x3_stream #(
		.PIXEL_BITS(PIXEL_BITS),
		.MAX_COLS  (MAX_COLS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: geometry, raster position, two line stores and
	// the two older window columns (top, mid, bottom each).
	// ------------------------------------------------------------------
	logic [COLS_REG_W-1:0]  cols_reg = mf3_pkg::COLS_RESET;
	logic [ROWS_REG_W-1:0]  rows_reg = mf3_pkg::ROWS_RESET;
	int                     row_pos  = 0;
	int                     col_pos  = 0;
	logic [PIX_FIELD_W-1:0] line_upper [MAX_COLS];  // row r-2
	logic [PIX_FIELD_W-1:0] line_lower [MAX_COLS];  // row r-1
	logic [PIX_FIELD_W-1:0] win [6] = '{default: '0};

	result_t   due [$];        // results still owed by the block, oldest first
	stim_row_t dir_tab [$];

	int   px_taken   = 0;
	int   cfg_writes = 0;
	int   res_seen   = 0;
	int   med_cnt    = 0;
	int   border_cnt = 0;
	int   err_cnt    = 0;
	int   mism_cnt   = 0;
	int   burst_left = 0;
	int   hold_left  = 0;
	int   hold_done  = 0;
	logic hold_req   = 1'b0;

	// ------------------------------------------------------------------
	// Median of nine by a plain bubble sort.
	// ------------------------------------------------------------------
	function automatic logic [PIX_FIELD_W-1:0] median_of_nine(
		input logic [8:0][PIX_FIELD_W-1:0] v
	);
		logic [PIX_FIELD_W-1:0] s [9];
		logic [PIX_FIELD_W-1:0] t;
		int i;
		int j;
		for (i = 0; i < 9; i++) s[i] = v[i];
		for (i = 0; i < 8; i++)
			for (j = 0; j < 8 - i; j++)
				if (s[j] > s[j+1]) begin
					t      = s[j];
					s[j]   = s[j+1];
					s[j+1] = t;
				end
		return s[4];
	endfunction

	// ------------------------------------------------------------------
	// Advance the window by one accepted pixel and queue what it yields.
	// A typed row replaces the computed results with the hand-written one;
	// the state is still stepped so later rows stay in sync.
	// ------------------------------------------------------------------
	task automatic window_step(input logic [PIX_FIELD_W-1:0] pix, input logic typed,
		input result_t want);
		int ecols;
		int erows;
		int n;
		int k;
		logic [PIX_FIELD_W-1:0] top;
		logic [PIX_FIELD_W-1:0] mid;
		logic [8:0][PIX_FIELD_W-1:0] nine;
		logic err;
		logic last;
		result_t made [2];

		// zero dimension steps like one, columns clamp at the store depth
		ecols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg));
		erows = (rows_reg == 0) ? 1 : int'(rows_reg);
		if (row_pos >= erows || col_pos >= ecols) begin
			row_pos = 0;
			col_pos = 0;
		end
		err  = (cols_reg < 3) || (rows_reg < 3);
		last = (row_pos == erows - 1) && (col_pos == ecols - 1);
		n    = 0;

		if (err) begin
			made[n] = {16'h0000, 16'(row_pos), 10'(col_pos), 1'b1, last};
			n++;
			err_cnt++;
		end else begin
			top = line_upper[col_pos];
			mid = line_lower[col_pos];
			line_upper[col_pos] = mid;
			line_lower[col_pos] = pix;
			// the pixel at (r, c) completes the window centered on (r-1, c-1)
			if (row_pos >= 2 && col_pos >= 2) begin
				nine = {pix, mid, top, win[5], win[4], win[3], win[2], win[1], win[0]};
				made[n] = {median_of_nine(nine), 16'(row_pos - 1), 10'(col_pos - 1),
					1'b0, 1'b0};
				n++;
				med_cnt++;
			end
			if (row_pos == 0 || row_pos == erows - 1 || col_pos == 0 || col_pos == ecols - 1) begin
				made[n] = {pix, 16'(row_pos), 10'(col_pos), 1'b0, last};
				n++;
				border_cnt++;
			end
			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = top;
			win[4] = mid;
			win[5] = pix;
		end

		col_pos++;
		if (col_pos >= ecols) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= erows) row_pos = 0;
		end

		if (typed) due.push_back(want);
		else for (k = 0; k < n; k++) due.push_back(made[k]);
	endtask

	// ------------------------------------------------------------------
	// Stimulus rows for the directed table.
	// ------------------------------------------------------------------
	function automatic stim_row_t px_row(input logic [PIX_FIELD_W-1:0] p);
		return {ROW_PIX, 1'b0, p, 1'b0, result_t'(0)};
	endfunction

	function automatic stim_row_t border_row(input logic [PIX_FIELD_W-1:0] p,
		input logic [ROW_FIELD_W-1:0] r, input logic [COL_FIELD_W-1:0] c, input logic last);
		return {ROW_PIX, 1'b0, p, 1'b1, {p, r, c, 1'b0, last}};
	endfunction

	// size error: pixel value is dropped, only the position survives
	function automatic stim_row_t err_row(input logic [ROW_FIELD_W-1:0] r,
		input logic [COL_FIELD_W-1:0] c, input logic last);
		return {ROW_PIX, 1'b0, 16'($urandom), 1'b1, {16'h0000, r, c, 1'b1, last}};
	endfunction

	function automatic stim_row_t cfg_row(input logic idx, input logic [CFG_DATA_W-1:0] d);
		return {ROW_CFG, idx, d, 1'b0, result_t'(0)};
	endfunction

	function automatic logic [PIX_FIELD_W-1:0] pick_pixel(input pix_style_t st, input int i,
		input logic [PIX_FIELD_W-1:0] base);
		case (st)
			PX_NARROW:  return base + 16'($urandom_range(0, 3));   // many ties
			PX_EXTREME: begin
				case ($urandom_range(0, 3))
					0:       return 16'h0000;
					1:       return 16'hFFFF;
					2:       return 16'h8000;
					default: return 16'h7FFF;
				endcase
			end
			PX_RAMP:    return base + 16'(i * 37) + 16'($urandom_range(0, 15));
			default:    return 16'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of random length, random gaps in between. A gap of
	// zero leaves stretches with tvalid held high across requests.
	// ------------------------------------------------------------------
	task automatic send_pixel(input logic [PIX_FIELD_W-1:0] pix, input logic typed,
		input result_t want);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
			                                          : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		px_taken++;
		window_step(pix, typed, want);
	endtask

	// Stop offering pixels, let every owed result drain, then give the
	// pipeline time to finish pixels that produce nothing.
	task automatic settle_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (due.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
	endtask

	// Register write; always taken on an idle block. Any write restarts
	// the frame at the top-left corner.
	task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] d);
		settle_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_IMAGE_COLS) cols_reg = d[COLS_REG_W-1:0];
		else                       rows_reg = d[ROWS_REG_W-1:0];
		row_pos = 0;
		col_pos = 0;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: its own stall pattern, switching mode at random, plus
	// one long hold-off during the over-wide frame, where every pixel
	// yields a result, so the block fills and pushes back on the sender.
	// ------------------------------------------------------------------
	rx_mode_t   rx_mode = RX_OPEN;
	int         rx_left = 0;
	logic [7:0] rx_pat  = 8'b1011_0010;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (hold_done == 0 && hold_req) begin
			hold_done = HOLD_CYC;
			hold_left = HOLD_CYC - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 80);
			end else begin
				rx_left--;
			end
			rx_pat = {rx_pat[6:0], rx_pat[7]};
			case (rx_mode)
				RX_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
				RX_PATTERN: m_axis_tready <= rx_pat[0];
				default:    m_axis_tready <= 1'b1;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Checker: every accepted result against the oldest owed result.
	// Padding above the column field must stay zero.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			res_seen++;
			got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[41:32],
				m_axis_tuser, m_axis_tlast};
			if (due.size() == 0) begin
				mism_cnt++;
				$display("%0t: unexpected result pix=%h row=%0d col=%0d err=%b last=%b",
					$time, got.pix, got.row, got.col, got.err, got.last);
			end else begin
				want = due.pop_front();
				if (got !== want || m_axis_tdata[47:42] !== 6'b0) begin
					mism_cnt++;
					$display("%0t: expected %h r%0d c%0d e%b l%b, got %h r%0d c%0d e%b l%b pad %h",
						$time, want.pix, want.row, want.col, want.err, want.last,
						got.pix, got.row, got.col, got.err, got.last, m_axis_tdata[47:42]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		int rnd_px;
		int sel;
		int cols;
		int rows;
		int ecols;
		int erows;
		int n;
		int i;
		int drain_at;
		pix_style_t style;
		logic [PIX_FIELD_W-1:0] base;

		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_IMAGE_COLS;
		cfg_data      = '0;
		arst_n        = 1'b0;
		rnd_px        = 0;

		// reset geometry 3x3: extremes, one median and the frame end
		dir_tab.push_back(border_row(16'h0000, 16'd0, 10'd0, 1'b0));
		dir_tab.push_back(border_row(16'hFFFF, 16'd0, 10'd1, 1'b0));
		dir_tab.push_back(border_row(16'h8000, 16'd0, 10'd2, 1'b0));
		dir_tab.push_back(border_row(16'h0001, 16'd1, 10'd0, 1'b0));
		dir_tab.push_back(px_row(16'h7FFF));                   // center, nothing yet
		dir_tab.push_back(border_row(16'h1234, 16'd1, 10'd2, 1'b0));
		dir_tab.push_back(border_row(16'hFFFF, 16'd2, 10'd0, 1'b0));
		dir_tab.push_back(border_row(16'h0000, 16'd2, 10'd1, 1'b0));
		dir_tab.push_back(px_row(16'hAAAA));                   // median, then last border
		// too few columns: every pixel is an error
		dir_tab.push_back(cfg_row(REG_IMAGE_COLS, 16'd2));
		dir_tab.push_back(err_row(16'd0, 10'd0, 1'b0));
		dir_tab.push_back(err_row(16'd0, 10'd1, 1'b0));
		dir_tab.push_back(err_row(16'd1, 10'd0, 1'b0));
		dir_tab.push_back(err_row(16'd1, 10'd1, 1'b0));
		dir_tab.push_back(err_row(16'd2, 10'd0, 1'b0));
		dir_tab.push_back(err_row(16'd2, 10'd1, 1'b1));
		// both dimensions zero: one-pixel frames, each result is the last
		dir_tab.push_back(cfg_row(REG_IMAGE_COLS, 16'd0));
		dir_tab.push_back(cfg_row(REG_IMAGE_ROWS, 16'd0));
		dir_tab.push_back(err_row(16'd0, 10'd0, 1'b1));
		dir_tab.push_back(err_row(16'd0, 10'd0, 1'b1));
		// wide enough but a single row
		dir_tab.push_back(cfg_row(REG_IMAGE_COLS, 16'd4));
		dir_tab.push_back(cfg_row(REG_IMAGE_ROWS, 16'd1));
		dir_tab.push_back(err_row(16'd0, 10'd0, 1'b0));
		dir_tab.push_back(err_row(16'd0, 10'd1, 1'b0));
		dir_tab.push_back(err_row(16'd0, 10'd2, 1'b0));
		dir_tab.push_back(err_row(16'd0, 10'd3, 1'b1));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].idx, dir_tab[i].data);
			else send_pixel(dir_tab[i].data, dir_tab[i].typed, dir_tab[i].want);
		end

		// random phases: mostly whole frames of modest size, some partial
		// frames cut by the next register write, some error geometries
		while (rnd_px < RND_PIXELS) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				cols = $urandom_range(0, 4);
				rows = (cols < 3) ? $urandom_range(0, 6) : $urandom_range(0, 2);
			end else if (sel == 1) begin
				cols = $urandom_range(9, 40);
				rows = $urandom_range(3, 5);
			end else begin
				cols = $urandom_range(3, 8);
				rows = $urandom_range(3, 7);
			end
			// upper bits of the column write are ignored by the block
			if ($urandom_range(0, 1)) begin
				write_reg(REG_IMAGE_COLS, {5'($urandom), 11'(cols)});
				write_reg(REG_IMAGE_ROWS, 16'(rows));
			end else begin
				write_reg(REG_IMAGE_ROWS, 16'(rows));
				write_reg(REG_IMAGE_COLS, {5'($urandom), 11'(cols)});
			end
			ecols = (cols == 0) ? 1 : cols;
			erows = (rows == 0) ? 1 : rows;
			n = ecols * erows * ((sel == 1) ? 1 : $urandom_range(1, 3));
			if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
			if (n > RND_PIXELS - rnd_px) n = RND_PIXELS - rnd_px;
			style    = pix_style_t'($urandom_range(0, 3));
			base     = 16'($urandom);
			drain_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
			for (i = 0; i < n; i++) begin
				// sender pause mid-frame until everything owed has come back
				if (i == drain_at) begin
					@(negedge clk);
					s_axis_tvalid <= 1'b0;
					burst_left = 0;
					while (due.size() != 0) @(posedge clk);
				end
				send_pixel(pick_pixel(style, i, base), 1'b0, result_t'(0));
				rnd_px++;
			end
		end

		// widest setting: all-ones columns clamp to the store depth, all-ones
		// rows; the start of the first row is all border copies, sent while
		// the receiver holds off
		write_reg(REG_IMAGE_COLS, 16'hFFFF);
		write_reg(REG_IMAGE_ROWS, 16'hFFFF);
		hold_req = 1'b1;
		for (i = 0; i < WIDE_PIXELS; i++)
			send_pixel(16'($urandom), 1'b0, result_t'(0));

		settle_idle();

		$display("run covered %0d pixels, %0d register writes, %0d results checked",
			px_taken, cfg_writes, res_seen);
		$display("medians %0d, border copies %0d, size errors %0d, receiver hold %0d cycles",
			med_cnt, border_cnt, err_cnt, hold_done);
		if (mism_cnt == 0 && due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout: %0d results still owed", due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/mf3_pkg.sv
src/median_filter_3x3_stream.sv
verif/tb_top.sv
